>>> src/pdr_pkg.sv
// ----------------------------------------------------------------------------
// pdr_pkg
// types, constants and the cordic angle table for planar pose dead reckoning
// ----------------------------------------------------------------------------
`default_nettype none

package pdr_pkg;

	localparam int ANGLE_BITS_DEF = 16;
	localparam int POS_BITS_DEF   = 32;

	localparam int CORDIC_ITERS = 16;
	localparam int MUL_BITS     = 16;
	localparam int CS_W         = 18;
	localparam int Z_W          = 25;
	localparam logic signed [CS_W-1:0] CORDIC_X0 = 18'sd39797;

	typedef struct packed {
		logic signed [15:0] forward_speed;
		logic signed [15:0] lateral_speed;
		logic signed [15:0] yaw_rate;
		logic        [15:0] elapsed_time;
	} pdr_in_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic        [15:0] heading;
		logic               saturated;
	} pdr_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CORDIC,
		ST_ROT,
		ST_SCALE,
		ST_FINISH
	} pdr_state_t;

	// atan(2^-i) in units of 2^-24 turn
	function automatic logic signed [Z_W-1:0] atan24(input logic [3:0] i);
		logic signed [Z_W-1:0] r;
		case (i)
			4'd0:    r = 25'sd2097152;
			4'd1:    r = 25'sd1238021;
			4'd2:    r = 25'sd654136;
			4'd3:    r = 25'sd332050;
			4'd4:    r = 25'sd166669;
			4'd5:    r = 25'sd83416;
			4'd6:    r = 25'sd41718;
			4'd7:    r = 25'sd20860;
			4'd8:    r = 25'sd10430;
			4'd9:    r = 25'sd5215;
			4'd10:   r = 25'sd2608;
			4'd11:   r = 25'sd1304;
			4'd12:   r = 25'sd652;
			4'd13:   r = 25'sd326;
			4'd14:   r = 25'sd163;
			4'd15:   r = 25'sd81;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

>>> src/planar_pose_dead_reckoning.sv
// After a request is accepted the block runs 16 cordic iterations, the
// bit-serial rotate and scale passes and the pose update. A new request is
// taken only in idle, after the shared cordic stage, the two shift-add multiplier
// passes at one multiplier bit per cycle and the pose update, which can stall on out_ready.
// Reset: arst_n clears x, y and heading to zero and empties the result register.
// ----------------------------------------------------------------------------
// planar_pose_dead_reckoning
// keeps a planar pose and advances it by one body-frame velocity request
// ----------------------------------------------------------------------------
`default_nettype none

module planar_pose_dead_reckoning #(
	parameter int ANGLE_BITS = pdr_pkg::ANGLE_BITS_DEF,
	parameter int POS_BITS   = pdr_pkg::POS_BITS_DEF
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	output logic             in_ready,
	input  wire pdr_pkg::pdr_in_t in_data,
	output logic             out_valid,
	input  wire              out_ready,
	output pdr_pkg::pdr_out_t out_data
);
	import pdr_pkg::*;

	localparam int DW  = 30;
	localparam int SW  = ((POS_BITS > DW) ? POS_BITS : DW) + 1;
	localparam int XW  = (POS_BITS > 32) ? POS_BITS : 32;
	localparam int SH  = 24 - ANGLE_BITS;
	localparam logic [3:0] LAST = 4'(MUL_BITS - 1);
	localparam logic [3:0] CLAST = 4'(CORDIC_ITERS - 1);

	pdr_state_t state_q, state_d;
	logic       accept, load;

	logic [3:0] cnt_q;

	logic signed [POS_BITS-1:0]   pos_x_q, pos_y_q;
	logic        [ANGLE_BITS-1:0] head_q;

	logic signed [15:0] vf_q, vl_q, yr_q;
	logic        [15:0] dt_q;

	logic signed [CS_W-1:0] cx_q, cy_q;
	logic signed [Z_W-1:0]  z_q;
	logic        [1:0]      quad_q;

	logic signed [19:0] hx_q, hy_q;
	logic        [15:0] lox_q, loy_q;
	logic signed [36:0] ax_q, ay_q;
	logic signed [16:0] ah_q;
	logic        [15:0] loh_q;

	logic     out_valid_q;
	pdr_out_t out_q;

	// heading to cordic start
	logic [23:0]           a24, a24p, z0;
	logic [1:0]            quad;

	always_comb begin
		a24  = 24'(head_q) << SH;
		a24p = a24 + 24'h200000;
		quad = a24p[23:22];
		z0   = a24 - {quad, 22'd0};
	end

	// cordic iteration
	logic signed [CS_W-1:0] cx_sh, cy_sh;
	logic signed [Z_W-1:0]  atan_w;

	always_comb begin
		cx_sh  = cx_q >>> cnt_q;
		cy_sh  = cy_q >>> cnt_q;
		atan_w = atan24(cnt_q);
	end

	// quadrant fold
	logic signed [CS_W-1:0] c_w, s_w;

	always_comb begin
		case (quad_q)
			2'd0: begin
				c_w = cx_q;
				s_w = cy_q;
			end
			2'd1: begin
				c_w = -cy_q;
				s_w = cx_q;
			end
			2'd2: begin
				c_w = -cx_q;
				s_w = -cy_q;
			end
			default: begin
				c_w = cy_q;
				s_w = -cx_q;
			end
		endcase
	end

	// rotate step, one bit of each speed per cycle
	logic signed [18:0] tx, ty;
	logic signed [20:0] sum_x, sum_y;

	always_comb begin
		tx = (vf_q[0] ? 19'(c_w) : 19'sd0) - (vl_q[0] ? 19'(s_w) : 19'sd0);
		ty = (vf_q[0] ? 19'(s_w) : 19'sd0) + (vl_q[0] ? 19'(c_w) : 19'sd0);
		sum_x = 21'(hx_q) + ((cnt_q == LAST) ? -21'(tx) : 21'(tx));
		sum_y = 21'(hy_q) + ((cnt_q == LAST) ? -21'(ty) : 21'(ty));
	end

	// scale step, one bit of elapsed time per cycle
	logic signed [35:0] wx, wy;
	logic signed [37:0] sum_ax, sum_ay;
	logic signed [17:0] sum_h;

	always_comb begin
		wx     = $signed({hx_q, lox_q});
		wy     = $signed({hy_q, loy_q});
		sum_ax = 38'(ax_q) + (dt_q[0] ? 38'(wx) : 38'sd0);
		sum_ay = 38'(ay_q) + (dt_q[0] ? 38'(wy) : 38'sd0);
		sum_h  = 18'(ah_q) + (dt_q[0] ? 18'(yr_q) : 18'sd0);
	end

	// pose update
	logic signed [37:0]         rx, ry;
	logic signed [DW-1:0]       dx, dy;
	logic signed [SW-1:0]       sx, sy, hi_lim, lo_lim;
	logic signed [POS_BITS-1:0] new_x, new_y;
	logic                       sat_x, sat_y;
	logic signed [XW-1:0]       px_ext, py_ext;

	always_comb begin
		rx     = 38'(ax_q) + 38'sd128;
		ry     = 38'(ay_q) + 38'sd128;
		dx     = rx[37:8];
		dy     = ry[37:8];
		hi_lim = {{(SW - POS_BITS + 1){1'b0}}, {(POS_BITS - 1){1'b1}}};
		lo_lim = ~hi_lim;
		sx     = SW'(pos_x_q) + SW'(dx);
		sy     = SW'(pos_y_q) + SW'(dy);
		sat_x  = (sx > hi_lim) || (sx < lo_lim);
		sat_y  = (sy > hi_lim) || (sy < lo_lim);
		if (sx > hi_lim) begin
			new_x = hi_lim[POS_BITS-1:0];
		end else if (sx < lo_lim) begin
			new_x = lo_lim[POS_BITS-1:0];
		end else begin
			new_x = sx[POS_BITS-1:0];
		end
		if (sy > hi_lim) begin
			new_y = hi_lim[POS_BITS-1:0];
		end else if (sy < lo_lim) begin
			new_y = lo_lim[POS_BITS-1:0];
		end else begin
			new_y = sy[POS_BITS-1:0];
		end
		px_ext = XW'(new_x);
		py_ext = XW'(new_y);
	end

	// heading update
	logic signed [32:0]           dth;
	logic        [ANGLE_BITS-1:0] dth_a, new_h;
	logic        [15:0]           h16;

	assign dth = $signed({ah_q, loh_q});

	generate
		if (SH == 0) begin : g_no_round
			assign dth_a = dth[ANGLE_BITS-1:0];
		end else begin : g_round
			logic signed [33:0] dth_w, dth_r;
			assign dth_w = 34'(dth) + (34'sd1 <<< (SH - 1));
			assign dth_r = dth_w >>> SH;
			assign dth_a = dth_r[ANGLE_BITS-1:0];
		end
	endgenerate

	assign new_h = head_q + dth_a;

	generate
		if (ANGLE_BITS >= 16) begin : g_h_down
			assign h16 = new_h[ANGLE_BITS-1 -: 16];
		end else begin : g_h_up
			assign h16 = {new_h, {(16 - ANGLE_BITS){1'b0}}};
		end
	endgenerate

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		load     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_CORDIC;
				end
			end
			ST_CORDIC: begin
				if (cnt_q == CLAST) begin
					state_d = ST_ROT;
				end
			end
			ST_ROT: begin
				if (cnt_q == LAST) begin
					state_d = ST_SCALE;
				end
			end
			ST_SCALE: begin
				if (cnt_q == LAST) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					load    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			pos_x_q     <= '0;
			pos_y_q     <= '0;
			head_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept || state_q == ST_FINISH) begin
				cnt_q <= '0;
			end else if (state_q == ST_CORDIC || state_q == ST_ROT ||
				state_q == ST_SCALE) begin
				cnt_q <= cnt_q + 4'd1;
			end
			if (load) begin
				pos_x_q     <= new_x;
				pos_y_q     <= new_y;
				head_q      <= new_h;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			vf_q   <= in_data.forward_speed;
			vl_q   <= in_data.lateral_speed;
			yr_q   <= in_data.yaw_rate;
			dt_q   <= in_data.elapsed_time;
			cx_q   <= CORDIC_X0;
			cy_q   <= '0;
			z_q    <= Z_W'($signed(z0));
			quad_q <= quad;
			hx_q   <= '0;
			hy_q   <= '0;
			ax_q   <= '0;
			ay_q   <= '0;
			ah_q   <= '0;
		end
		case (state_q)
			ST_CORDIC: begin
				if (!z_q[Z_W-1]) begin
					cx_q <= cx_q - cy_sh;
					cy_q <= cy_q + cx_sh;
					z_q  <= z_q - atan_w;
				end else begin
					cx_q <= cx_q + cy_sh;
					cy_q <= cy_q - cx_sh;
					z_q  <= z_q + atan_w;
				end
			end
			ST_ROT: begin
				hx_q  <= sum_x[20:1];
				hy_q  <= sum_y[20:1];
				lox_q <= {sum_x[0], lox_q[15:1]};
				loy_q <= {sum_y[0], loy_q[15:1]};
				vf_q  <= vf_q >>> 1;
				vl_q  <= vl_q >>> 1;
			end
			ST_SCALE: begin
				ax_q  <= sum_ax[37:1];
				ay_q  <= sum_ay[37:1];
				ah_q  <= sum_h[17:1];
				loh_q <= {sum_h[0], loh_q[15:1]};
				dt_q  <= dt_q >> 1;
			end
			default: begin
			end
		endcase
		if (load) begin
			out_q.pos_x     <= px_ext[31:0];
			out_q.pos_y     <= py_ext[31:0];
			out_q.heading   <= h16;
			out_q.saturated <= sat_x || sat_y;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTH
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_CORDIC) && (cnt_q == 4'd0))
		else $error("request accepted but cordic did not start");

	a_load_gives_valid: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> out_valid_q)
		else $error("pose update without a result");

	a_heading_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!load |=> $stable(head_q))
		else $error("heading changed outside an update");

	a_sat_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.saturated) |->
			(pos_x_q == hi_lim[POS_BITS-1:0]) || (pos_x_q == lo_lim[POS_BITS-1:0]) ||
			(pos_y_q == hi_lim[POS_BITS-1:0]) || (pos_y_q == lo_lim[POS_BITS-1:0]))
		else $error("saturated flag without a clamped position");
`endif

endmodule

`default_nettype wire
